/* rtl/scw_pkg.sv */
// Shared types, constants and helpers for the smooth cutoff weight pipeline.
// No dependencies; every other file in rtl/ imports this package.
package scw_pkg;

    localparam int DIST_W    = 24;   // Q8.16 distance and radii
    localparam int VAL_W     = 48;   // Q15.32 coefficients and results
    localparam int ACC_W     = 64;   // Horner accumulator, |acc| <= 2^62
    localparam int NUM_STEPS = 5;    // Horner steps for a degree-5 polynomial
    localparam int NUM_LANES = 3;    // weight, slope, curvature
    localparam int NUM_COEF  = 6;

    localparam int ADDR_W = 6;       // eight 64-bit registers at 8*i
    localparam int DATA_W = 64;

    typedef logic        [DIST_W-1:0] t_dist;
    typedef logic signed [VAL_W-1:0]  t_val;
    typedef logic signed [ACC_W-1:0]  t_acc;

    // Register indexes (paddr[5:3])
    localparam logic [2:0] REG_INNER  = 3'd0;
    localparam logic [2:0] REG_CUTOFF = 3'd1;
    localparam logic [2:0] REG_COEF0  = 3'd2;
    localparam logic [2:0] REG_COEF1  = 3'd3;
    localparam logic [2:0] REG_COEF2  = 3'd4;
    localparam logic [2:0] REG_COEF3  = 3'd5;
    localparam logic [2:0] REG_COEF4  = 3'd6;
    localparam logic [2:0] REG_COEF5  = 3'd7;

    localparam t_acc ACC_LIM = 64'sh4000_0000_0000_0000;
    localparam t_acc OUT_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam t_acc OUT_MIN = -64'sh0000_8000_0000_0000;

    // Clamp an accumulator to the 48-bit result range.
    function automatic t_val sat48(t_acc v);
        t_acc c;
        if (v > OUT_MAX) begin
            c = OUT_MAX;
        end else if (v < OUT_MIN) begin
            c = OUT_MIN;
        end else begin
            c = v;
        end
        return c[VAL_W-1:0];
    endfunction

endpackage

/* rtl/scw_stream_if.sv */
// Valid/ready stream interfaces for distance items and weight results.
// Depends on scw_pkg for the payload types.
interface scw_in_if;
    import scw_pkg::*;
    logic  valid;
    logic  ready;
    t_dist distance;
    modport source (output valid, output distance, input ready);
    modport sink   (input valid, input distance, output ready);
endinterface

interface scw_out_if;
    import scw_pkg::*;
    logic valid;
    logic ready;
    t_val weight;
    t_val slope;
    t_val curvature;
    modport source (output valid, output weight, output slope, output curvature,
                    input ready);
    modport sink   (input valid, input weight, input slope, input curvature,
                    output ready);
endinterface

/* rtl/scw_step.sv */
// One Horner step: acc * r >> 16 (round half away from zero), clamp, add coef, clamp.
// Two register stages: split multiply, then round/saturate/add. Uses scw_pkg.
module scw_step
    import scw_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_en,
    input  t_acc  i_acc,
    input  t_dist i_dist,
    input  t_acc  i_coef,
    output t_acc  o_acc
);

    localparam int HP_W = 55;   // 31-bit high half times 24-bit distance
    localparam int LP_W = 56;   // 32-bit low half times 24-bit distance
    localparam logic [62:0] MAG_LIM = 63'h4000_0000_0000_0000;
    localparam logic signed [64:0] TOT_LIM = 65'sh0_4000_0000_0000_0000;

    logic              r_neg;
    logic [HP_W-1:0]   r_hp;
    logic [LP_W-1:0]   r_lp;
    t_acc              r_acc;

    t_acc              abs_acc;
    logic [LP_W:0]     lp_rnd;
    logic [62:0]       sum;
    logic [62:0]       mag;
    t_acc              prod;
    logic signed [64:0] tot;
    t_acc              n_acc;

    // Stage A: magnitude split in two halves, each fits one multiplier
    assign abs_acc = i_acc[ACC_W-1] ? -i_acc : i_acc;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_neg <= i_acc[ACC_W-1];
            r_hp  <= HP_W'(abs_acc[62:32]) * HP_W'(i_dist);
            r_lp  <= LP_W'(abs_acc[31:0]) * LP_W'(i_dist);
        end
    end

    // Stage B: recombine, round, saturate, add the next coefficient
    always_comb begin
        lp_rnd = {1'b0, r_lp} + (LP_W+1)'(16'h8000);
        sum    = {1'b0, r_hp[45:0], 16'b0} + 63'(lp_rnd[LP_W:16]);
        if (r_hp[HP_W-1:46] != '0) begin
            mag = MAG_LIM;
        end else if (sum > MAG_LIM) begin
            mag = MAG_LIM;
        end else begin
            mag = sum;
        end
        prod = r_neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
        tot  = 65'(prod) + 65'(i_coef);
        if (tot > TOT_LIM) begin
            n_acc = ACC_LIM;
        end else if (tot < -TOT_LIM) begin
            n_acc = -ACC_LIM;
        end else begin
            n_acc = tot[ACC_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_acc <= n_acc;
        end
    end

    assign o_acc = r_acc;

endmodule

/* rtl/smooth_cutoff_weight_poly.sv */
// Smooth cutoff weight: quintic polynomial P(r) with P'(r) and P''(r), Q15.32 out.
// Accepts one transaction per cycle while the output register is empty or being drained.
// Synchronous active-low reset clears the pipeline valid bits and the configuration registers.
// Depends on scw_pkg, scw_stream_if (scw_in_if, scw_out_if) and scw_step.
module smooth_cutoff_weight_poly
    import scw_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,

    // APB-style configuration port, register i at byte address 8*i
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready,

    scw_in_if.sink            i_in,
    scw_out_if.source         o_out
);

    // Pipeline layout:
    //   stage 0         : range checks, pick evaluation point, flags
    //   stages 1..10    : five Horner steps, two stages each, three lanes
    //   output register : saturate to 48 bits and apply the zero flags
    // All stages advance together when the output register is empty or
    // being drained, so a stall holds every transaction in place.
    localparam int LAST = 2 * NUM_STEPS;   // index of the last step stage

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_dist      r_inner;
    t_dist      r_cutoff;
    t_val       r_coef [NUM_COEF];
    logic [2:0] cfg_idx;
    logic       cfg_wr;

    assign cfg_idx = paddr[ADDR_W-1:3];
    assign cfg_wr  = psel & penable & pwrite;
    assign pready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inner  <= '0;
            r_cutoff <= '0;
            for (int k = 0; k < NUM_COEF; k++) begin
                r_coef[k] <= '0;
            end
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INNER:  r_inner   <= pwdata[DIST_W-1:0];
                REG_CUTOFF: r_cutoff  <= pwdata[DIST_W-1:0];
                REG_COEF0:  r_coef[0] <= pwdata[VAL_W-1:0];
                REG_COEF1:  r_coef[1] <= pwdata[VAL_W-1:0];
                REG_COEF2:  r_coef[2] <= pwdata[VAL_W-1:0];
                REG_COEF3:  r_coef[3] <= pwdata[VAL_W-1:0];
                REG_COEF4:  r_coef[4] <= pwdata[VAL_W-1:0];
                REG_COEF5:  r_coef[5] <= pwdata[VAL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            REG_INNER:  prdata = DATA_W'(r_inner);
            REG_CUTOFF: prdata = DATA_W'(r_cutoff);
            REG_COEF0:  prdata = DATA_W'(r_coef[0]);
            REG_COEF1:  prdata = DATA_W'(r_coef[1]);
            REG_COEF2:  prdata = DATA_W'(r_coef[2]);
            REG_COEF3:  prdata = DATA_W'(r_coef[3]);
            REG_COEF4:  prdata = DATA_W'(r_coef[4]);
            REG_COEF5:  prdata = DATA_W'(r_coef[5]);
            default:    prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Lane coefficients. Configuration is static while items flow, so the
    // derivative multiples are plain shift-and-add logic off the registers.
    // Shorter polynomials get zero leading terms: a zero accumulator times
    // r stays zero, so the extra steps leave the result unchanged.
    // ------------------------------------------------------------------
    t_acc c [NUM_COEF];
    t_acc lane_coef [NUM_LANES][NUM_COEF];

    always_comb begin
        for (int k = 0; k < NUM_COEF; k++) begin
            c[k] = ACC_W'(r_coef[k]);
        end
        // weight: c0..c5
        for (int k = 0; k < NUM_COEF; k++) begin
            lane_coef[0][k] = c[k];
        end
        // slope: c1, 2c2, 3c3, 4c4, 5c5
        lane_coef[1][0] = c[1];
        lane_coef[1][1] = c[2] <<< 1;
        lane_coef[1][2] = (c[3] <<< 1) + c[3];
        lane_coef[1][3] = c[4] <<< 2;
        lane_coef[1][4] = (c[5] <<< 2) + c[5];
        lane_coef[1][5] = '0;
        // curvature: 2c2, 6c3, 12c4, 20c5
        lane_coef[2][0] = c[2] <<< 1;
        lane_coef[2][1] = (c[3] <<< 2) + (c[3] <<< 1);
        lane_coef[2][2] = (c[4] <<< 3) + (c[4] <<< 2);
        lane_coef[2][3] = (c[5] <<< 4) + (c[5] <<< 2);
        lane_coef[2][4] = '0;
        lane_coef[2][5] = '0;
    end

    // ------------------------------------------------------------------
    // Flow control: advance everything when the output slot is free
    // ------------------------------------------------------------------
    logic r_out_vld;
    logic adv;

    assign adv         = ~r_out_vld | o_out.ready;
    assign i_in.ready  = adv;

    // ------------------------------------------------------------------
    // Stage 0: range checks. Below the inner radius the weight is the
    // polynomial at the inner radius, so evaluate there and drop the
    // derivatives. Beyond the cutoff drop all three results.
    // ------------------------------------------------------------------
    logic  below;
    logic  beyond;

    assign below  = i_in.distance < r_inner;
    assign beyond = ~below & (i_in.distance > r_cutoff);

    logic  r_vld   [LAST+1];
    logic  r_zall  [LAST+1];
    logic  r_zder  [LAST+1];
    t_dist r_dist  [LAST+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= LAST; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (adv) begin
            r_vld[0] <= i_in.valid;
            for (int k = 1; k <= LAST; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // Payload side of the flag and distance lines, no reset needed
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_zall[0] <= beyond;
            r_zder[0] <= below;
            r_dist[0] <= below ? r_inner : i_in.distance;
            for (int k = 1; k <= LAST; k++) begin
                r_zall[k] <= r_zall[k-1];
                r_zder[k] <= r_zder[k-1];
                r_dist[k] <= r_dist[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Horner steps: step j reads the distance held at stage 2j and adds
    // coefficient 4-j; the first accumulator is the top coefficient.
    // ------------------------------------------------------------------
    t_acc acc [NUM_LANES][NUM_STEPS+1];

    for (genvar l = 0; l < NUM_LANES; l++) begin : g_lane
        assign acc[l][0] = lane_coef[l][NUM_COEF-1];
        for (genvar j = 0; j < NUM_STEPS; j++) begin : g_step
            scw_step u_step (
                .i_clk  (i_clk),
                .i_en   (adv),
                .i_acc  (acc[l][j]),
                .i_dist (r_dist[2*j]),
                .i_coef (lane_coef[l][NUM_COEF-2-j]),
                .o_acc  (acc[l][j+1])
            );
        end
    end

    // ------------------------------------------------------------------
    // Output register: saturate and apply the range flags
    // ------------------------------------------------------------------
    t_val r_weight;
    t_val r_slope;
    t_val r_curv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= r_vld[LAST];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_weight <= r_zall[LAST] ? '0 : sat48(acc[0][NUM_STEPS]);
            r_slope  <= (r_zall[LAST] | r_zder[LAST]) ? '0 : sat48(acc[1][NUM_STEPS]);
            r_curv   <= (r_zall[LAST] | r_zder[LAST]) ? '0 : sat48(acc[2][NUM_STEPS]);
        end
    end

    assign o_out.valid     = r_out_vld;
    assign o_out.weight    = r_weight;
    assign o_out.slope     = r_slope;
    assign o_out.curvature = r_curv;

endmodule

/* tb/sv/smooth_cutoff_weight_poly_tb.sv */
// Self-checking testbench for smooth_cutoff_weight_poly: APB register writes,
// random distance streams with stalls, and a scoreboard that predicts weight,
// slope and curvature. Depends on scw_pkg, scw_in_if and scw_out_if.
module smooth_cutoff_weight_poly_tb;
    import scw_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Idle cycles with no transaction anywhere before the run is declared hung
    localparam int STALL_LIMIT = 4000;
    localparam int NUM_PHASES  = 12;
    localparam int PHASE_ITEMS = 70;
    localparam int HOLD_CYCLES = 150;

    // Scoreboard: carries its own copy of the register file, predicts the
    // three results for every accepted distance and checks them in order.
    class weight_scoreboard;
        typedef struct {
            t_val weight;
            t_val slope;
            t_val curvature;
        } t_weight_triple;

        t_dist          inner_r;
        t_dist          cutoff_r;
        t_acc           coef[6];
        t_weight_triple expected_weights[$];
        int             errors;

        function new();
            inner_r  = '0;
            cutoff_r = '0;
            foreach (coef[k]) coef[k] = '0;
            errors   = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
            t_val v;
            v = value[VAL_W-1:0];
            case (idx)
                REG_INNER: begin
                    inner_r = value[DIST_W-1:0];
                end
                REG_CUTOFF: begin
                    cutoff_r = value[DIST_W-1:0];
                end
                default: begin
                    coef[idx - REG_COEF0] = v;   // sign-extend Q15.32
                end
            endcase
        endfunction

        function t_acc clip_acc(t_acc v);
            if (v > ACC_LIM) return ACC_LIM;
            if (v < -ACC_LIM) return -ACC_LIM;
            return v;
        endfunction

        // Multiply by r (Q8.16), drop 16 fraction bits, round half away from zero
        function t_acc scale_by_r(t_acc a, t_dist r);
            logic        neg;
            logic [63:0] m, mh, ml, hp, lp, mag;
            neg = a < 0;
            m   = neg ? -a : a;
            mh  = m >> 32;
            ml  = m & 64'hFFFF_FFFF;
            hp  = mh * {40'd0, r};
            lp  = ml * {40'd0, r};
            if (hp >= (64'd1 << 46)) begin
                mag = ACC_LIM;
            end else begin
                mag = (hp << 16) + ((lp + 64'h8000) >> 16);
                if (mag > ACC_LIM) mag = ACC_LIM;
            end
            return neg ? -t_acc'(mag) : t_acc'(mag);
        endfunction

        function t_acc horner_eval(t_acc d[6], int n, t_dist r);
            t_acc acc;
            acc = clip_acc(d[n-1]);
            for (int k = n - 2; k >= 0; k--) begin
                acc = scale_by_r(acc, r);
                acc = clip_acc(acc + d[k]);
            end
            return acc;
        endfunction

        function t_val to_result(t_acc v);
            if (v > OUT_MAX) v = OUT_MAX;
            if (v < OUT_MIN) v = OUT_MIN;
            return v[VAL_W-1:0];
        endfunction

        function t_weight_triple predict_weight(t_dist r);
            t_acc           slope_poly[6];
            t_acc           curv_poly[6];
            t_weight_triple res;
            res.weight    = '0;
            res.slope     = '0;
            res.curvature = '0;
            if (r < inner_r) begin
                // flat core: value pinned at the inner radius
                res.weight = to_result(horner_eval(coef, 6, inner_r));
            end else if (r <= cutoff_r) begin
                slope_poly[0] = coef[1];
                slope_poly[1] = coef[2] * 2;
                slope_poly[2] = coef[3] * 3;
                slope_poly[3] = coef[4] * 4;
                slope_poly[4] = coef[5] * 5;
                slope_poly[5] = '0;
                curv_poly[0]  = coef[2] * 2;
                curv_poly[1]  = coef[3] * 6;
                curv_poly[2]  = coef[4] * 12;
                curv_poly[3]  = coef[5] * 20;
                curv_poly[4]  = '0;
                curv_poly[5]  = '0;
                res.weight    = to_result(horner_eval(coef, 6, r));
                res.slope     = to_result(horner_eval(slope_poly, 5, r));
                res.curvature = to_result(horner_eval(curv_poly, 4, r));
            end
            return res;
        endfunction

        function void note_distance(t_dist r);
            expected_weights.push_back(predict_weight(r));
        endfunction

        function void compare_field(string name, t_val exp_v, t_val act_v);
            if (act_v !== exp_v) begin
                errors++;
                $display("%0t: %s mismatch: expected %h, actual %h",
                         $time, name, exp_v, act_v);
            end
        endfunction

        function void check_result(t_val w, t_val s, t_val c);
            t_weight_triple want;
            if (expected_weights.size() == 0) begin
                errors++;
                $display("%0t: unexpected result: expected none, actual %h %h %h",
                         $time, w, s, c);
                return;
            end
            want = expected_weights.pop_front();
            compare_field("weight", want.weight, w);
            compare_field("slope", want.slope, s);
            compare_field("curvature", want.curvature, c);
        endfunction

        function int pending();
            return expected_weights.size();
        endfunction
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    scw_in_if  in_bus ();
    scw_out_if out_bus ();

    weight_scoreboard weights_sb;

    // Stimulus-side view of the current radii, used to aim distances
    t_dist cur_inner;
    t_dist cur_cutoff;
    // Per-phase idling switches and the one-shot receiver hold-off
    logic  tx_idling;
    logic  rx_idling;
    int    hold_request;

    smooth_cutoff_weight_poly dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .i_in    (in_bus),
        .o_out   (out_bus)
    );

    always #1 i_clk = ~i_clk;

    // APB write: setup cycle, then access cycle; mirror into the scoreboard
    // at the edge where the register takes the value.
    task automatic write_reg(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        weights_sb.set_reg(idx, value);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Offer one distance; valid stays high across back-to-back transactions.
    task automatic send_distance(input t_dist r);
        int gap;
        gap = tx_idling ? $urandom_range(0, 10) : 0;
        @(negedge i_clk);
        if (gap > 0) begin
            in_bus.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_bus.valid    <= 1'b1;
        in_bus.distance <= r;
        @(posedge i_clk);
        while (!in_bus.ready) @(posedge i_clk);
        weights_sb.note_distance(r);
    endtask

    // Drop valid and wait until every predicted result has come back.
    task automatic drain();
        @(negedge i_clk);
        in_bus.valid <= 1'b0;
        while (weights_sb.pending() != 0) @(posedge i_clk);
    endtask

    function automatic t_val random_coef(int shift);
        logic [63:0] raw;
        t_val        v;
        raw = {$urandom, $urandom};
        v   = raw[VAL_W-1:0];
        return v >>> shift;
    endfunction

    function automatic t_dist boundary_distance(int which);
        case (which)
            0:       return '0;
            1:       return '1;
            2:       return cur_inner - 24'd1;
            3:       return cur_inner;
            4:       return cur_inner + 24'd1;
            5:       return cur_cutoff - 24'd1;
            6:       return cur_cutoff;
            default: return cur_cutoff + 24'd1;
        endcase
    endfunction

    // Mostly aim at the live region, with radius edges and full-range noise.
    function automatic t_dist pick_distance();
        int sel;
        int hi;
        sel = $urandom_range(0, 99);
        if (sel < 15) return boundary_distance($urandom_range(0, 7));
        if (sel < 35) return t_dist'($urandom);
        hi = int'(cur_cutoff) + int'(cur_cutoff >> 3) + 16;
        if (hi > 32'hFF_FFFF) hi = 32'hFF_FFFF;
        return t_dist'($urandom_range(0, hi));
    endfunction

    // Pick radii and coefficients for one phase and write all eight registers.
    task automatic configure(input int phase);
        t_val coefs[6];
        int   shift;
        case (phase)
            0: begin
                // full range, every coefficient at its positive limit
                cur_inner  = '0;
                cur_cutoff = '1;
                foreach (coefs[k]) coefs[k] = OUT_MAX[VAL_W-1:0];
            end
            1: begin
                // every coefficient at its negative limit, small flat core
                cur_inner  = 24'h01_8000;
                cur_cutoff = '1;
                foreach (coefs[k]) coefs[k] = OUT_MIN[VAL_W-1:0];
            end
            2: begin
                // inner above cutoff: flat value below inner, zero elsewhere
                cur_inner  = t_dist'($urandom_range(24'h01_0000, 24'h04_0000));
                cur_cutoff = cur_inner >> 1;
                foreach (coefs[k]) coefs[k] = random_coef(20);
            end
            3: begin
                cur_inner  = t_dist'($urandom_range(24'h00_8000, 24'h03_0000));
                cur_cutoff = cur_inner;
                foreach (coefs[k]) coefs[k] = random_coef(16);
            end
            4: begin
                // radii at opposite extremes
                cur_inner  = '1;
                cur_cutoff = '0;
                foreach (coefs[k]) coefs[k] = random_coef(0);
            end
            default: begin
                if ($urandom_range(0, 3) == 0) begin
                    cur_inner  = t_dist'($urandom);
                    cur_cutoff = t_dist'($urandom);
                    foreach (coefs[k]) coefs[k] = random_coef($urandom_range(0, 47));
                end else begin
                    cur_inner  = t_dist'($urandom_range(0, 24'h01_0000));
                    cur_cutoff = cur_inner + t_dist'($urandom_range(0, 24'h04_0000));
                    foreach (coefs[k]) begin
                        shift    = $urandom_range(8, 36);
                        coefs[k] = random_coef(shift);
                    end
                end
            end
        endcase
        // upper data bits carry junk; the block keeps only the field width
        write_reg(REG_INNER, {32'($urandom), 8'($urandom), cur_inner});
        write_reg(REG_CUTOFF, {32'($urandom), 8'($urandom), cur_cutoff});
        for (int k = 0; k < 6; k++) begin
            write_reg(REG_COEF0 + 3'(k), {16'($urandom), coefs[k]});
        end
        // idling per phase: two pressure phases, one phase at full rate
        tx_idling = 1'b1;
        rx_idling = 1'b1;
        if (phase == 5 || phase == 9) begin
            tx_idling    = 1'b0;
            hold_request = HOLD_CYCLES;
        end else if (phase == 6) begin
            tx_idling = 1'b0;
            rx_idling = 1'b0;
        end
    endtask

    // Result side: draw a wait per transaction; a pending hold-off request
    // replaces the draw so the pipeline backs up into the input.
    initial begin : result_sink
        int wait_cycles;
        out_bus.ready = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            wait_cycles = rx_idling ? $urandom_range(0, 10) : 0;
            if (hold_request > 0) begin
                wait_cycles  = hold_request;
                hold_request = 0;
            end
            @(negedge i_clk);
            if (wait_cycles > 0) begin
                out_bus.ready <= 1'b0;
                repeat (wait_cycles) @(negedge i_clk);
            end
            out_bus.ready <= 1'b1;
            @(posedge i_clk);
            while (!out_bus.valid) @(posedge i_clk);
        end
    end

    // Check every result transaction against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && out_bus.valid && out_bus.ready) begin
            weights_sb.check_result(out_bus.weight, out_bus.slope, out_bus.curvature);
        end
    end

    // Hang detector: any transaction or register access restarts the count
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) ||
                (psel && penable)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    initial begin : stimulus
        i_rst_n         = 1'b0;
        psel            = 1'b0;
        penable         = 1'b0;
        pwrite          = 1'b0;
        paddr           = '0;
        pwdata          = '0;
        in_bus.valid    = 1'b0;
        in_bus.distance = '0;
        cur_inner       = '0;
        cur_cutoff      = '0;
        tx_idling       = 1'b1;
        rx_idling       = 1'b1;
        hold_request    = 0;
        weights_sb      = new();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: radii zero, all coefficients zero
        for (int b = 0; b < 8; b++) send_distance(boundary_distance(b));
        drain();

        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            configure(phase);
            // hit both radius edges first under the saturating settings
            if (phase < 2) begin
                for (int b = 0; b < 8; b++) send_distance(boundary_distance(b));
            end
            for (int n = 0; n < PHASE_ITEMS; n++) send_distance(pick_distance());
            drain();
        end

        // allow for stray results past the pipeline depth
        repeat (30) @(posedge i_clk);
        if (weights_sb.errors == 0 && weights_sb.pending() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
